@@ hdl/cftp_pkg.sv @@
`default_nettype none
package cftp_pkg;

   // result status codes
   typedef enum logic [2:0] {
      ST_CIRCLE    = 3'd0,
      ST_DIAMETER  = 3'd1,
      ST_FEW       = 3'd2,
      ST_COLLINEAR = 3'd3,
      ST_SMALL     = 3'd4
   } status_type;

   typedef logic [1:0] csr_index_type;

   localparam csr_index_type CSR_COLLINEAR_LIMIT = 2'd0;
   localparam csr_index_type CSR_COINCIDE_LIMIT  = 2'd1;
   localparam csr_index_type CSR_MIN_RADIUS      = 2'd2;

   localparam int CSR_DATA_BITS = 32;
   localparam int MIN_RADIUS_BITS = 16;

   localparam logic [CSR_DATA_BITS-1:0]   COLLINEAR_LIMIT_RESET = 32'd1;
   localparam logic [CSR_DATA_BITS-1:0]   COINCIDE_LIMIT_RESET  = 32'd1;
   localparam logic [MIN_RADIUS_BITS-1:0] MIN_RADIUS_RESET      = 16'd1;

endpackage
`default_nettype wire

@@ hdl/cftp_geom.sv @@
`default_nettype none
module cftp_geom #(
   parameter int W = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [1:0]            in_count,
   input  logic signed [W-1:0]   in_x1,
   input  logic signed [W-1:0]   in_y1,
   input  logic signed [W-1:0]   in_x2,
   input  logic signed [W-1:0]   in_y2,
   input  logic signed [W-1:0]   in_x3,
   input  logic signed [W-1:0]   in_y3,
   input  logic [31:0]           collinear_limit,
   input  logic [31:0]           coincide_limit,
   output logic                  out_valid,
   output cftp_pkg::status_type  out_status,
   output logic [3*W+3:0]        out_tx,
   output logic [3*W+3:0]        out_ty,
   output logic [3*W+3:0]        out_d,
   output logic                  out_negx,
   output logic                  out_negy,
   output logic [2*W:0]          out_ra,
   output logic signed [W-1:0]   out_x1,
   output logic signed [W-1:0]   out_y1,
   output logic signed [W-1:0]   out_hx,
   output logic signed [W-1:0]   out_hy
);
   import cftp_pkg::*;

   localparam int D  = W + 1;
   localparam int P  = 2 * W + 2;
   localparam int RW = 2 * W + 1;
   localparam int CW = 2 * W + 2;
   localparam int H  = W + 1;
   localparam int QW = 2 * W + 3;
   localparam int NW = 3 * W + 3;
   localparam int DV = 3 * W + 4;

   logic [6:0] v_ff;

   // stage 1: edge vectors and diameter midpoint
   logic [1:0]          cnt1_ff;
   logic signed [W-1:0] x1_1_ff, y1_1_ff, hx1_ff, hy1_ff;
   logic signed [D-1:0] ax1_ff, ay1_ff, bx1_ff, by1_ff, ex1_ff, ey1_ff;
   logic signed [W+1:0] hsx_in, hsy_in;

   assign hsx_in = (W+2)'(in_x1) + (W+2)'(in_x2) + (W+2)'(1);
   assign hsy_in = (W+2)'(in_y1) + (W+2)'(in_y2) + (W+2)'(1);

   always_ff @(posedge clock) begin
      if (en) begin
         cnt1_ff <= in_count;
         x1_1_ff <= in_x1;
         y1_1_ff <= in_y1;
         hx1_ff  <= hsx_in[W:1];
         hy1_ff  <= hsy_in[W:1];
         ax1_ff  <= D'(in_x2) - D'(in_x1);
         ay1_ff  <= D'(in_y2) - D'(in_y1);
         bx1_ff  <= D'(in_x3) - D'(in_x1);
         by1_ff  <= D'(in_y3) - D'(in_y1);
         ex1_ff  <= D'(in_x3) - D'(in_x2);
         ey1_ff  <= D'(in_y3) - D'(in_y2);
      end
   end

   // stage 2: products
   logic [1:0]          cnt2_ff;
   logic signed [W-1:0] x1_2_ff, y1_2_ff, hx2_ff, hy2_ff;
   logic signed [D-1:0] ax2_ff, ay2_ff, bx2_ff, by2_ff;
   logic signed [P-1:0] axby_ff, aybx_ff, axax_ff, ayay_ff, bxbx_ff, byby_ff, exex_ff, eyey_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         cnt2_ff <= cnt1_ff;
         x1_2_ff <= x1_1_ff;
         y1_2_ff <= y1_1_ff;
         hx2_ff  <= hx1_ff;
         hy2_ff  <= hy1_ff;
         ax2_ff  <= ax1_ff;
         ay2_ff  <= ay1_ff;
         bx2_ff  <= bx1_ff;
         by2_ff  <= by1_ff;
         axby_ff <= P'(ax1_ff) * P'(by1_ff);
         aybx_ff <= P'(ay1_ff) * P'(bx1_ff);
         axax_ff <= P'(ax1_ff) * P'(ax1_ff);
         ayay_ff <= P'(ay1_ff) * P'(ay1_ff);
         bxbx_ff <= P'(bx1_ff) * P'(bx1_ff);
         byby_ff <= P'(by1_ff) * P'(by1_ff);
         exex_ff <= P'(ex1_ff) * P'(ex1_ff);
         eyey_ff <= P'(ey1_ff) * P'(ey1_ff);
      end
   end

   // stage 3: cross product and squared lengths
   logic [1:0]           cnt3_ff;
   logic signed [W-1:0]  x1_3_ff, y1_3_ff, hx3_ff, hy3_ff;
   logic signed [D-1:0]  ax3_ff, ay3_ff, bx3_ff, by3_ff;
   logic signed [CW-1:0] cross3_ff;
   logic [RW-1:0]        ra3_ff, rb3_ff, s23_3_ff;
   logic signed [P-1:0]  ra_in, rb_in, s23_in;

   assign ra_in  = axax_ff + ayay_ff;
   assign rb_in  = bxbx_ff + byby_ff;
   assign s23_in = exex_ff + eyey_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         cnt3_ff   <= cnt2_ff;
         x1_3_ff   <= x1_2_ff;
         y1_3_ff   <= y1_2_ff;
         hx3_ff    <= hx2_ff;
         hy3_ff    <= hy2_ff;
         ax3_ff    <= ax2_ff;
         ay3_ff    <= ay2_ff;
         bx3_ff    <= bx2_ff;
         by3_ff    <= by2_ff;
         cross3_ff <= axby_ff - aybx_ff;
         ra3_ff    <= ra_in[RW-1:0];
         rb3_ff    <= rb_in[RW-1:0];
         s23_3_ff  <= s23_in[RW-1:0];
      end
   end

   // stage 4: classify, partial products of the numerators
   status_type           status4_ff, status_in;
   logic signed [W-1:0]  x1_4_ff, y1_4_ff, hx4_ff, hy4_ff;
   logic [RW-1:0]        ra4_ff;
   logic [CW-1:0]        cmag_in, cmag4_ff;
   logic                 cneg4_ff;
   logic signed [QW-1:0] palby_ff, pahby_ff, pblay_ff, pbhay_ff;
   logic signed [QW-1:0] pblax_ff, pbhax_ff, palbx_ff, pahbx_ff;
   logic signed [QW-1:0] ralo_s, rahi_s, rblo_s, rbhi_s;

   assign cmag_in = cross3_ff[CW-1] ? CW'(-cross3_ff) : CW'(cross3_ff);
   assign ralo_s  = QW'($signed({1'b0, ra3_ff[H-1:0]}));
   assign rahi_s  = QW'($signed({1'b0, ra3_ff[RW-1:H]}));
   assign rblo_s  = QW'($signed({1'b0, rb3_ff[H-1:0]}));
   assign rbhi_s  = QW'($signed({1'b0, rb3_ff[RW-1:H]}));

   always_comb begin
      if (cnt3_ff < 2'd2) begin
         status_in = ST_FEW;
      end else if (cnt3_ff == 2'd2 || s23_3_ff < RW'(coincide_limit)) begin
         status_in = ST_DIAMETER;
      end else if (cmag_in == '0 || cmag_in < CW'(collinear_limit)) begin
         status_in = ST_COLLINEAR;
      end else begin
         status_in = ST_CIRCLE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         status4_ff <= status_in;
         x1_4_ff    <= x1_3_ff;
         y1_4_ff    <= y1_3_ff;
         hx4_ff     <= hx3_ff;
         hy4_ff     <= hy3_ff;
         ra4_ff     <= ra3_ff;
         cmag4_ff   <= cmag_in;
         cneg4_ff   <= cross3_ff[CW-1];
         palby_ff   <= ralo_s * QW'(by3_ff);
         pahby_ff   <= rahi_s * QW'(by3_ff);
         pblay_ff   <= rblo_s * QW'(ay3_ff);
         pbhay_ff   <= rbhi_s * QW'(ay3_ff);
         pblax_ff   <= rblo_s * QW'(ax3_ff);
         pbhax_ff   <= rbhi_s * QW'(ax3_ff);
         palbx_ff   <= ralo_s * QW'(bx3_ff);
         pahbx_ff   <= rahi_s * QW'(bx3_ff);
      end
   end

   // stage 5: full products
   status_type           status5_ff;
   logic signed [W-1:0]  x1_5_ff, y1_5_ff, hx5_ff, hy5_ff;
   logic [RW-1:0]        ra5_ff;
   logic [CW-1:0]        cmag5_ff;
   logic                 cneg5_ff;
   logic signed [NW-1:0] raby_ff, rbay_ff, rbax_ff, rabx_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         status5_ff <= status4_ff;
         x1_5_ff    <= x1_4_ff;
         y1_5_ff    <= y1_4_ff;
         hx5_ff     <= hx4_ff;
         hy5_ff     <= hy4_ff;
         ra5_ff     <= ra4_ff;
         cmag5_ff   <= cmag4_ff;
         cneg5_ff   <= cneg4_ff;
         raby_ff    <= (NW'(pahby_ff) <<< H) + NW'(palby_ff);
         rbay_ff    <= (NW'(pbhay_ff) <<< H) + NW'(pblay_ff);
         rbax_ff    <= (NW'(pbhax_ff) <<< H) + NW'(pblax_ff);
         rabx_ff    <= (NW'(pahbx_ff) <<< H) + NW'(palbx_ff);
      end
   end

   // stage 6: numerators
   status_type           status6_ff;
   logic signed [W-1:0]  x1_6_ff, y1_6_ff, hx6_ff, hy6_ff;
   logic [RW-1:0]        ra6_ff;
   logic [CW-1:0]        cmag6_ff;
   logic                 cneg6_ff;
   logic signed [NW-1:0] nx6_ff, ny6_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         status6_ff <= status5_ff;
         x1_6_ff    <= x1_5_ff;
         y1_6_ff    <= y1_5_ff;
         hx6_ff     <= hx5_ff;
         hy6_ff     <= hy5_ff;
         ra6_ff     <= ra5_ff;
         cmag6_ff   <= cmag5_ff;
         cneg6_ff   <= cneg5_ff;
         nx6_ff     <= raby_ff - rbay_ff;
         ny6_ff     <= rbax_ff - rabx_ff;
      end
   end

   // stage 7: dividend with rounding bias, divisor 2|c|
   logic [NW-1:0] nxmag_in, nymag_in;

   assign nxmag_in = nx6_ff[NW-1] ? NW'(-nx6_ff) : NW'(nx6_ff);
   assign nymag_in = ny6_ff[NW-1] ? NW'(-ny6_ff) : NW'(ny6_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         out_status <= status6_ff;
         out_x1     <= x1_6_ff;
         out_y1     <= y1_6_ff;
         out_hx     <= hx6_ff;
         out_hy     <= hy6_ff;
         out_ra     <= ra6_ff;
         out_tx     <= DV'(nxmag_in) + DV'(cmag6_ff);
         out_ty     <= DV'(nymag_in) + DV'(cmag6_ff);
         out_d      <= DV'(cmag6_ff) << 1;
         out_negx   <= nx6_ff[NW-1] ^ cneg6_ff;
         out_negy   <= ny6_ff[NW-1] ^ cneg6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[5:0], in_valid};
      end
   end

   assign out_valid = v_ff[6];

endmodule
`default_nettype wire

@@ hdl/cftp_div.sv @@
`default_nettype none
module cftp_div #(
   parameter int W      = 32,
   parameter int SIDE_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [3*W+3:0]      in_tx,
   input  logic [3*W+3:0]      in_ty,
   input  logic [3*W+3:0]      in_d,
   input  logic                in_negx,
   input  logic                in_negy,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output logic signed [W+1:0] out_offx,
   output logic signed [W+1:0] out_offy,
   output logic [SIDE_W-1:0]   out_side
);
   localparam int DV = 3 * W + 4;

   logic [W:0]        v_ff;
   logic [W:0]        negx_ff, negy_ff, clampx_ff, clampy_ff;
   logic [DV-1:0]     remx_ff [W+1];
   logic [DV-1:0]     remy_ff [W+1];
   logic [DV-1:0]     d_ff    [W+1];
   logic [W-1:0]      qx_ff   [W+1];
   logic [W-1:0]      qy_ff   [W+1];
   logic [SIDE_W-1:0] side_ff [W+1];

   // entry: quotients of 2^W or more saturate
   always_ff @(posedge clock) begin
      if (en) begin
         remx_ff[0]   <= in_tx;
         remy_ff[0]   <= in_ty;
         d_ff[0]      <= in_d;
         qx_ff[0]     <= '0;
         qy_ff[0]     <= '0;
         negx_ff[0]   <= in_negx;
         negy_ff[0]   <= in_negy;
         clampx_ff[0] <= in_tx >= (in_d << W);
         clampy_ff[0] <= in_ty >= (in_d << W);
         side_ff[0]   <= in_side;
      end
   end

   // one quotient bit per stage, msb first
   for (genvar j = 1; j <= W; j++) begin : g_stage
      localparam int K = W - j;
      logic [DV-1:0] trial;
      logic [DV-1:0] remx_in, remy_in;
      logic [W-1:0]  qx_in, qy_in;

      always_comb begin
         trial   = d_ff[j-1] << K;
         remx_in = remx_ff[j-1];
         remy_in = remy_ff[j-1];
         qx_in   = qx_ff[j-1];
         qy_in   = qy_ff[j-1];
         if (remx_ff[j-1] >= trial) begin
            remx_in  = remx_ff[j-1] - trial;
            qx_in[K] = 1'b1;
         end
         if (remy_ff[j-1] >= trial) begin
            remy_in  = remy_ff[j-1] - trial;
            qy_in[K] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            remx_ff[j]   <= remx_in;
            remy_ff[j]   <= remy_in;
            d_ff[j]      <= d_ff[j-1];
            qx_ff[j]     <= qx_in;
            qy_ff[j]     <= qy_in;
            negx_ff[j]   <= negx_ff[j-1];
            negy_ff[j]   <= negy_ff[j-1];
            clampx_ff[j] <= clampx_ff[j-1];
            clampy_ff[j] <= clampy_ff[j-1];
            side_ff[j]   <= side_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[W-1:0], in_valid};
      end
   end

   logic signed [W+1:0] magx, magy;

   assign magx = clampx_ff[W] ? ((W+2)'(1) <<< W) : $signed({2'b00, qx_ff[W]});
   assign magy = clampy_ff[W] ? ((W+2)'(1) <<< W) : $signed({2'b00, qy_ff[W]});

   assign out_offx  = negx_ff[W] ? -magx : magx;
   assign out_offy  = negy_ff[W] ? -magy : magy;
   assign out_valid = v_ff[W];
   assign out_side  = side_ff[W];

endmodule
`default_nettype wire

@@ hdl/cftp_sqrt.sv @@
`default_nettype none
module cftp_sqrt #(
   parameter int W      = 32,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [2*W+1:0]    in_s,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [W:0]        out_root,
   output logic [2*W+1:0]    out_rem,
   output logic [SIDE_W-1:0] out_side
);
   localparam int SW = 2 * W + 2;
   localparam int NS = W + 1;

   logic [NS:0]       v_ff;
   logic [SW-1:0]     rem_ff  [NS+1];
   logic [W:0]        root_ff [NS+1];
   logic [SIDE_W-1:0] side_ff [NS+1];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= in_s;
         root_ff[0] <= '0;
         side_ff[0] <= in_side;
      end
   end

   // one root bit per stage; rem stays s - root^2
   for (genvar j = 1; j <= NS; j++) begin : g_stage
      localparam int B = NS - j;
      logic [SW-1:0] trial, rem_in;
      logic [W:0]    root_in;

      always_comb begin
         trial   = (SW'(root_ff[j-1]) << (B + 1)) + (SW'(1) << (2 * B));
         rem_in  = rem_ff[j-1];
         root_in = root_ff[j-1];
         if (rem_ff[j-1] >= trial) begin
            rem_in     = rem_ff[j-1] - trial;
            root_in[B] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            root_ff[j] <= root_in;
            side_ff[j] <= side_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NS-1:0], in_valid};
      end
   end

   assign out_valid = v_ff[NS];
   assign out_root  = root_ff[NS];
   assign out_rem   = rem_ff[NS];
   assign out_side  = side_ff[NS];

endmodule
`default_nettype wire

@@ hdl/circle_from_three_points_top.sv @@
// path from item accept to result valid: geometry, divider, stages a and b, square root, output register
// throughput: one item per cycle; the whole pipeline advances together and holds
//   while a finished result waits on rsp_ready
// depth is set by the restoring divider (one quotient bit per stage) and the
//   square root (one root bit per stage)
// reset: synchronous, clears all valid bits and loads the csr defaults (all 1)
`default_nettype none
module circle_from_three_points_top #(
   parameter int COORD_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_point_count,
   input  logic signed [COORD_BITS-1:0]   req_first_x,
   input  logic signed [COORD_BITS-1:0]   req_first_y,
   input  logic signed [COORD_BITS-1:0]   req_second_x,
   input  logic signed [COORD_BITS-1:0]   req_second_y,
   input  logic signed [COORD_BITS-1:0]   req_third_x,
   input  logic signed [COORD_BITS-1:0]   req_third_y,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [COORD_BITS-1:0]   rsp_center_x,
   output logic signed [COORD_BITS-1:0]   rsp_center_y,
   output logic [COORD_BITS-2:0]          rsp_radius,
   output cftp_pkg::status_type           rsp_status,
   input  logic                           csr_write,
   input  cftp_pkg::csr_index_type        csr_index,
   input  logic [cftp_pkg::CSR_DATA_BITS-1:0] csr_data
);
   import cftp_pkg::*;

   localparam int W      = COORD_BITS;
   localparam int RW     = 2 * W + 1;
   localparam int DV     = 3 * W + 4;
   localparam int SW     = 2 * W + 2;
   localparam int DSIDE  = 3 + RW + 4 * W;
   localparam int SSIDE  = 3 + 2 * W;

   // ---------------------------------------------------------------- csr
   logic [CSR_DATA_BITS-1:0]   collinear_limit_ff;
   logic [CSR_DATA_BITS-1:0]   coincide_limit_ff;
   logic [MIN_RADIUS_BITS-1:0] min_radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         collinear_limit_ff <= COLLINEAR_LIMIT_RESET;
         coincide_limit_ff  <= COINCIDE_LIMIT_RESET;
         min_radius_ff      <= MIN_RADIUS_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_COLLINEAR_LIMIT: collinear_limit_ff <= csr_data;
            CSR_COINCIDE_LIMIT:  coincide_limit_ff  <= csr_data;
            CSR_MIN_RADIUS:      min_radius_ff      <= csr_data[MIN_RADIUS_BITS-1:0];
            default: ;
         endcase
      end
   end

   // one enable for every stage: advance unless a result is stuck at the output
   logic en;
   logic rsp_valid_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // ---------------------------------------------------------------- geometry
   logic                g_valid;
   status_type          g_status;
   logic [DV-1:0]       g_tx, g_ty, g_d;
   logic                g_negx, g_negy;
   logic [RW-1:0]       g_ra;
   logic signed [W-1:0] g_x1, g_y1, g_hx, g_hy;

   cftp_geom #(.W(W)) u_geom (
      .clock           (clock),
      .reset           (reset),
      .en              (en),
      .in_valid        (req_valid),
      .in_count        (req_point_count),
      .in_x1           (req_first_x),
      .in_y1           (req_first_y),
      .in_x2           (req_second_x),
      .in_y2           (req_second_y),
      .in_x3           (req_third_x),
      .in_y3           (req_third_y),
      .collinear_limit (collinear_limit_ff),
      .coincide_limit  (coincide_limit_ff),
      .out_valid       (g_valid),
      .out_status      (g_status),
      .out_tx          (g_tx),
      .out_ty          (g_ty),
      .out_d           (g_d),
      .out_negx        (g_negx),
      .out_negy        (g_negy),
      .out_ra          (g_ra),
      .out_x1          (g_x1),
      .out_y1          (g_y1),
      .out_hx          (g_hx),
      .out_hy          (g_hy)
   );

   // ---------------------------------------------------------------- divider
   // center offset from point one: rounded n / (2c), magnitude clamped to 2^W
   logic                d_valid;
   logic signed [W+1:0] d_offx, d_offy;
   logic [DSIDE-1:0]    d_side;

   cftp_div #(.W(W), .SIDE_W(DSIDE)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (g_valid),
      .in_tx     (g_tx),
      .in_ty     (g_ty),
      .in_d      (g_d),
      .in_negx   (g_negx),
      .in_negy   (g_negy),
      .in_side   ({g_status, g_ra, g_x1, g_y1, g_hx, g_hy}),
      .out_valid (d_valid),
      .out_offx  (d_offx),
      .out_offy  (d_offy),
      .out_side  (d_side)
   );

   status_type          ds_status;
   logic [RW-1:0]       ds_ra;
   logic signed [W-1:0] ds_x1, ds_y1, ds_hx, ds_hy;

   assign {ds_status, ds_ra, ds_x1, ds_y1, ds_hx, ds_hy} = d_side;

   // ---------------------------------------------------------------- stage a
   // circumcenter = point one + offset, saturated; diameter items use the midpoint
   localparam logic signed [W+2:0] CMAX = {4'b0000, {(W-1){1'b1}}};
   localparam logic signed [W+2:0] CMIN = {4'b1111, {(W-1){1'b0}}};

   logic signed [W+2:0] sumx_in, sumy_in;
   logic signed [W-1:0] cx_in, cy_in;
   logic                a_valid_ff;
   status_type          a_status_ff;
   logic [RW-1:0]       a_ra_ff;
   logic signed [W+1:0] a_offx_ff, a_offy_ff;
   logic signed [W-1:0] a_cx_ff, a_cy_ff;

   assign sumx_in = (W+3)'(ds_x1) + (W+3)'(d_offx);
   assign sumy_in = (W+3)'(ds_y1) + (W+3)'(d_offy);

   always_comb begin
      if (ds_status == ST_DIAMETER) begin
         cx_in = ds_hx;
         cy_in = ds_hy;
      end else begin
         cx_in = (sumx_in > CMAX) ? CMAX[W-1:0] :
                 (sumx_in < CMIN) ? CMIN[W-1:0] : sumx_in[W-1:0];
         cy_in = (sumy_in > CMAX) ? CMAX[W-1:0] :
                 (sumy_in < CMIN) ? CMIN[W-1:0] : sumy_in[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_status_ff <= ds_status;
         a_ra_ff     <= ds_ra;
         a_offx_ff   <= d_offx;
         a_offy_ff   <= d_offy;
         a_cx_ff     <= cx_in;
         a_cy_ff     <= cy_in;
      end
   end

   // ---------------------------------------------------------------- stage b
   // squares of the rounded offsets for the radius
   logic                b_valid_ff;
   status_type          b_status_ff;
   logic [RW-1:0]       b_ra_ff;
   logic [SW-1:0]       b_sqx_ff, b_sqy_ff;
   logic signed [W-1:0] b_cx_ff, b_cy_ff;
   logic signed [2*W+3:0] sqx_in, sqy_in;

   assign sqx_in = (2*W+4)'(a_offx_ff) * (2*W+4)'(a_offx_ff);
   assign sqy_in = (2*W+4)'(a_offy_ff) * (2*W+4)'(a_offy_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         b_status_ff <= a_status_ff;
         b_ra_ff     <= a_ra_ff;
         b_sqx_ff    <= sqx_in[SW-1:0];
         b_sqy_ff    <= sqy_in[SW-1:0];
         b_cx_ff     <= a_cx_ff;
         b_cy_ff     <= a_cy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= d_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   // ---------------------------------------------------------------- square root
   // shared by both kinds of circle: diameter takes |p2-p1|^2
   logic [SW-1:0]    s_in;
   logic             q_valid;
   logic [W:0]       q_root;
   logic [SW-1:0]    q_rem;
   logic [SSIDE-1:0] q_side;

   assign s_in = (b_status_ff == ST_DIAMETER) ? SW'(b_ra_ff) : b_sqx_ff + b_sqy_ff;

   cftp_sqrt #(.W(W), .SIDE_W(SSIDE)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (b_valid_ff),
      .in_s      (s_in),
      .in_side   ({b_status_ff, b_cx_ff, b_cy_ff}),
      .out_valid (q_valid),
      .out_root  (q_root),
      .out_rem   (q_rem),
      .out_side  (q_side)
   );

   status_type          qs_status;
   logic signed [W-1:0] qs_cx, qs_cy;

   assign {qs_status, qs_cx, qs_cy} = q_side;

   // ---------------------------------------------------------------- output stage
   // diameter radius: half the root, half rounds up; circumradius: nearest root
   localparam logic [W+1:0] RMAX = {3'b000, {(W-1){1'b1}}};

   logic [W+1:0]        rdia_sum, r_cir, r_sel;
   logic [W:0]          r_dia;
   status_type          status_in;
   logic signed [W-1:0] ocx_in, ocy_in;
   logic [W-2:0]        rad_in;

   status_type          rsp_status_ff;
   logic signed [W-1:0] rsp_cx_ff, rsp_cy_ff;
   logic [W-2:0]        rsp_radius_ff;

   assign rdia_sum = {1'b0, q_root} + (W+2)'(1);
   assign r_dia    = rdia_sum[W+1:1];
   assign r_cir    = {1'b0, q_root} + (W+2)'(q_rem > SW'(q_root));

   always_comb begin
      status_in = qs_status;
      ocx_in    = qs_cx;
      ocy_in    = qs_cy;
      r_sel     = '0;
      case (qs_status)
         ST_CIRCLE: begin
            r_sel = r_cir;
         end
         ST_DIAMETER: begin
            if (r_dia > (W+1)'(min_radius_ff)) begin
               r_sel = {1'b0, r_dia};
            end else begin
               status_in = ST_SMALL;
               ocx_in    = '0;
               ocy_in    = '0;
            end
         end
         default: begin
            // too few points or collinear: all fields zero
            ocx_in = '0;
            ocy_in = '0;
         end
      endcase
      rad_in = (r_sel > RMAX) ? RMAX[W-2:0] : r_sel[W-2:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_status_ff <= status_in;
         rsp_cx_ff     <= ocx_in;
         rsp_cy_ff     <= ocy_in;
         rsp_radius_ff <= rad_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_center_x = rsp_cx_ff;
   assign rsp_center_y = rsp_cy_ff;
   assign rsp_radius   = rsp_radius_ff;

endmodule
`default_nettype wire

@@ hdl/cftp_check.sv @@
`default_nettype none
module cftp_check #(
   parameter int COORD_BITS = 32
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic signed [COORD_BITS-1:0]   rsp_center_x,
   input logic signed [COORD_BITS-1:0]   rsp_center_y,
   input logic [COORD_BITS-2:0]          rsp_radius,
   input cftp_pkg::status_type           rsp_status
);
   import cftp_pkg::*;

   // a held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_radius)
         && $stable(rsp_center_x) && $stable(rsp_center_y))
      else $error("result changed while stalled");

   // input side only stalls when a result is stuck
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("ready does not follow output stall");

   // rejected items carry zero fields
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FEW || rsp_status == ST_COLLINEAR
         || rsp_status == ST_SMALL)
      |-> rsp_center_x == '0 && rsp_center_y == '0 && rsp_radius == '0)
      else $error("rejected item with nonzero fields");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind circle_from_three_points_top cftp_check #(.COORD_BITS(COORD_BITS)) u_check (.*);
`default_nettype wire

@@ tb/circle_from_three_points_top_test.sv @@
`timescale 1ns / 100ps
module circle_from_three_points_top_test;
   import cftp_pkg::*;

   // all geometry is done on wide signed words, far wider than any product here
   typedef logic signed [255:0] big_type;

   typedef struct {
      logic [1:0]         point_count;
      logic signed [31:0] first_x;
      logic signed [31:0] first_y;
      logic signed [31:0] second_x;
      logic signed [31:0] second_y;
      logic signed [31:0] third_x;
      logic signed [31:0] third_y;
   } point_set_type;

   typedef struct {
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic [30:0]        radius;
      status_type         status;
   } circle_type;

   localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
   localparam int WATCHDOG_CYCLES = 3000;
   localparam int SETTLE_CYCLES = 90;
   localparam int HOLD_OFF_CYCLES = 400;

   // circle predictor plus the queue of circles still owed by the block
   class circle_scoreboard;
      logic [31:0] collinear_lim;
      logic [31:0] coincide_lim;
      logic [15:0] min_rad;
      circle_type  owed[$];
      int          errors;
      int          items;
      int          status_seen[5];

      function new();
         collinear_lim = COLLINEAR_LIMIT_RESET;
         coincide_lim = COINCIDE_LIMIT_RESET;
         min_rad = MIN_RADIUS_RESET;
         errors = 0;
         items = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [31:0] data);
         case (idx)
            CSR_COLLINEAR_LIMIT: collinear_lim = data;
            CSR_COINCIDE_LIMIT: coincide_lim = data;
            CSR_MIN_RADIUS: min_rad = data[15:0];
            default: ;
         endcase
      endfunction

      function big_type sq_sum(longint a, longint b);
         big_type ba, bb;
         ba = a;
         bb = b;
         return ba * ba + bb * bb;
      endfunction

      function longint unsigned root_floor(big_type s);
         longint unsigned r, c;
         big_type c2;
         r = 0;
         for (int b = 62; b >= 0; b--) begin
            c = r | (64'd1 << b);
            c2 = big_type'(c) * big_type'(c);
            if (c2 <= s) r = c;
         end
         return r;
      endfunction

      // n / 2c rounded half away from zero, magnitude clamped to 2^32
      function longint center_offset(big_type n, big_type c);
         big_type nm, cm, q;
         longint mag;
         nm = n < 0 ? -n : n;
         cm = c < 0 ? -c : c;
         q = (nm + cm) / (cm + cm);
         if (q > big_type'(64'h1_0000_0000)) q = big_type'(64'h1_0000_0000);
         mag = q[63:0];
         return ((n < 0) != (c < 0)) ? -mag : mag;
      endfunction

      function logic signed [31:0] clamp_coord(longint v);
         if (v > longint'(COORD_MAX)) return COORD_MAX;
         if (v < longint'(COORD_MIN)) return COORD_MIN;
         return v[31:0];
      endfunction

      function logic [30:0] clamp_radius(longint unsigned r);
         return r > 64'h7FFF_FFFF ? 31'h7FFF_FFFF : r[30:0];
      endfunction

      function circle_type circle_of(point_set_type p);
         circle_type r;
         longint x1, y1, x2, y2, x3, y3, ax, ay, bx, by, ox, oy;
         big_type c, cm, ra, rb, nx, ny, s;
         longint unsigned rt;
         bit on_diameter;
         r.center_x = 0;
         r.center_y = 0;
         r.radius = 0;
         r.status = ST_FEW;
         x1 = p.first_x;  y1 = p.first_y;
         x2 = p.second_x; y2 = p.second_y;
         x3 = p.third_x;  y3 = p.third_y;
         if (p.point_count < 2) return r;
         on_diameter = (p.point_count == 2) ||
                       (sq_sum(x3 - x2, y3 - y2) < big_type'(coincide_lim));
         if (on_diameter) begin
            rt = (root_floor(sq_sum(x2 - x1, y2 - y1)) + 1) >> 1;
            if (rt > min_rad) begin
               r.status = ST_DIAMETER;
               r.radius = clamp_radius(rt);
               r.center_x = (x1 + x2 + 1) >>> 1;
               r.center_y = (y1 + y2 + 1) >>> 1;
            end else begin
               r.status = ST_SMALL;
            end
            return r;
         end
         ax = x2 - x1; ay = y2 - y1;
         bx = x3 - x1; by = y3 - y1;
         c = big_type'(ax) * big_type'(by) - big_type'(ay) * big_type'(bx);
         cm = c < 0 ? -c : c;
         // zero cross product is collinear even with a zero limit
         if (cm == 0 || cm < big_type'(collinear_lim)) begin
            r.status = ST_COLLINEAR;
            return r;
         end
         ra = sq_sum(ax, ay);
         rb = sq_sum(bx, by);
         nx = ra * big_type'(by) - rb * big_type'(ay);
         ny = rb * big_type'(ax) - ra * big_type'(bx);
         ox = center_offset(nx, c);
         oy = center_offset(ny, c);
         s = sq_sum(ox, oy);
         rt = root_floor(s);
         if (s > big_type'(rt) * big_type'(rt) + big_type'(rt)) rt++;
         r.status = ST_CIRCLE;
         r.radius = clamp_radius(rt);
         r.center_x = clamp_coord(x1 + ox);
         r.center_y = clamp_coord(y1 + oy);
         return r;
      endfunction

      function void note_item(point_set_type p);
         owed = {owed, circle_of(p)};
         items++;
      endfunction

      function void check_circle(circle_type got);
         circle_type want;
         if (owed.size() == 0) begin
            $display("%0t: circle with none pending: status %0d", $time, got.status);
            errors++;
            return;
         end
         want = owed.pop_front();
         if (got.status <= ST_SMALL) status_seen[got.status]++;
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
         end
         if (got.center_x !== want.center_x) begin
            $display("%0t: center_x expected %0d actual %0d", $time,
                     want.center_x, got.center_x);
            errors++;
         end
         if (got.center_y !== want.center_y) begin
            $display("%0t: center_y expected %0d actual %0d", $time,
                     want.center_y, got.center_y);
            errors++;
         end
         if (got.radius !== want.radius) begin
            $display("%0t: radius expected %0d actual %0d", $time,
                     want.radius, got.radius);
            errors++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [1:0]        req_point_count;
   logic signed [31:0] req_first_x, req_first_y;
   logic signed [31:0] req_second_x, req_second_y;
   logic signed [31:0] req_third_x, req_third_y;
   logic              rsp_valid;
   logic              rsp_ready;
   logic signed [31:0] rsp_center_x, rsp_center_y;
   logic [30:0]       rsp_radius;
   status_type        rsp_status;
   logic              csr_write;
   csr_index_type     csr_index;
   logic [CSR_DATA_BITS-1:0] csr_data;

   circle_scoreboard circles = new();
   bit idle_on = 1'b1;        // random gaps on both sides
   bit hold_off_req = 1'b0;   // ask the receiver for one long stall
   int quiet_cycles = 0;

   circle_from_three_points_top #(.COORD_BITS(32)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_point_count(req_point_count),
      .req_first_x(req_first_x), .req_first_y(req_first_y),
      .req_second_x(req_second_x), .req_second_y(req_second_y),
      .req_third_x(req_third_x), .req_third_y(req_third_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_center_x(rsp_center_x), .rsp_center_y(rsp_center_y),
      .rsp_radius(rsp_radius), .rsp_status(rsp_status),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // watch both channels; values read here are the ones from before the edge
   always @(posedge clock) begin
      point_set_type p;
      circle_type got;
      if (!reset) begin
         if (req_valid && req_ready) begin
            p.point_count = req_point_count;
            p.first_x = req_first_x;   p.first_y = req_first_y;
            p.second_x = req_second_x; p.second_y = req_second_y;
            p.third_x = req_third_x;   p.third_y = req_third_y;
            circles.note_item(p);
         end
         if (rsp_valid && rsp_ready) begin
            got.center_x = rsp_center_x;
            got.center_y = rsp_center_y;
            got.radius = rsp_radius;
            got.status = rsp_status;
            circles.check_circle(got);
         end
      end
   end

   // watchdog: too long without any item moving means the block hung
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
         $display("timeout after %0d idle cycles", quiet_cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin
      forever begin
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   // offer one item, optionally after a gap, and wait for the handshake
   task automatic send_item(point_set_type p);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_point_count <= p.point_count;
      req_first_x <= p.first_x;   req_first_y <= p.first_y;
      req_second_x <= p.second_x; req_second_y <= p.second_y;
      req_third_x <= p.third_x;   req_third_y <= p.third_y;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // stop offering and let every owed circle come out
   task automatic drain();
      req_valid <= 1'b0;
      while (circles.owed.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // leaves the write strobe high; the caller drops it after the last write
   task automatic write_reg(csr_index_type idx, logic [31:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      circles.set_reg(idx, data);
      @(posedge clock);
   endtask

   task automatic set_limits(logic [31:0] col, logic [31:0] coin, logic [15:0] rmin);
      write_reg(CSR_COLLINEAR_LIMIT, col);
      write_reg(CSR_COINCIDE_LIMIT, coin);
      write_reg(CSR_MIN_RADIUS, {16'd0, rmin});
      csr_write <= 1'b0;
   endtask

   // coordinate with random magnitude, both signs
   function automatic logic signed [31:0] any_coord();
      return $signed($urandom) >>> $urandom_range(0, 28);
   endfunction

   function automatic logic signed [31:0] nudge();
      return $signed($urandom_range(0, 6)) - 3;
   endfunction

   function automatic point_set_type pts(logic [1:0] n, logic signed [31:0] a, b, c, d, e, f);
      point_set_type p;
      p.point_count = n;
      p.first_x = a;  p.first_y = b;
      p.second_x = c; p.second_y = d;
      p.third_x = e;  p.third_y = f;
      return p;
   endfunction

   // mostly three-point sets shaped to hit coincidence, collinearity and tiny triangles
   function automatic point_set_type random_points();
      point_set_type p;
      logic signed [31:0] dx, dy;
      int k;
      p = pts($urandom_range(0, 9) < 8 ? 2'd3 : 2'($urandom_range(0, 2)),
              any_coord(), any_coord(), any_coord(), any_coord(), any_coord(), any_coord());
      dx = any_coord() >>> 4;
      dy = any_coord() >>> 4;
      k = $urandom_range(0, 6) - 3;
      case ($urandom_range(0, 9))
         5: begin
            p.third_x = p.second_x + nudge();
            p.third_y = p.second_y + nudge();
         end
         6: begin
            p.second_x = p.first_x + dx;  p.second_y = p.first_y + dy;
            p.third_x = p.first_x + k * dx + nudge();
            p.third_y = p.first_y + k * dy;
         end
         7: begin
            p.third_x = p.second_x;
            p.third_y = p.second_y;
         end
         8: begin
            p.second_x = p.first_x + nudge() * 3;  p.second_y = p.first_y + nudge() * 5;
            p.third_x = p.first_x + nudge() * 7;   p.third_y = p.first_y + nudge() * 2;
         end
         9: begin
            p.first_x = $urandom;  p.first_y = $urandom;
            p.second_x = $urandom; p.second_y = $urandom;
            p.third_x = $urandom;  p.third_y = $urandom;
         end
         default: ;
      endcase
      return p;
   endfunction

   task automatic random_run(int n);
      repeat (n) send_item(random_points());
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_point_count <= 2'd0;
      req_first_x <= 0;  req_first_y <= 0;
      req_second_x <= 0; req_second_y <= 0;
      req_third_x <= 0;  req_third_y <= 0;
      csr_write <= 1'b0;
      csr_index <= CSR_COLLINEAR_LIMIT;
      csr_data <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed items with the reset limits
      send_item(pts(2'd0, 0, 0, 0, 0, 0, 0));                  // no points
      send_item(pts(2'd1, 5, 6, 7, 8, 9, 10));                 // one point
      send_item(pts(2'd2, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 0, 0));
      send_item(pts(2'd2, 100, 100, 100, 100, 9, 9));          // zero diameter
      send_item(pts(2'd2, 0, 0, 2, 0, 0, 0));                  // radius equals min
      send_item(pts(2'd2, 0, 0, 3, 0, 0, 0));                  // just above min
      send_item(pts(2'd2, -3, -5, 0, 0, COORD_MIN, COORD_MAX)); // third point ignored
      send_item(pts(2'd3, 0, 0, 32'sh30000, 32'sh10000, 32'sh30000, 32'sh10000));
      send_item(pts(2'd3, 0, 0, 32'sh10000, 32'sh20000, 32'sh20000, 32'sh40000));
      send_item(pts(2'd3, 0, 0, 32'sh10000, 0, 0, 32'sh10000)); // right triangle
      send_item(pts(2'd3, COORD_MIN, 0, COORD_MAX, 0, 0, 1));   // huge flat circle
      send_item(pts(2'd3, 0, 0, 1, 0, 0, 1));                   // smallest triangle
      send_item(pts(2'd3, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                       COORD_MAX));
      send_item(pts(2'd3, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                       COORD_MIN));
      send_item(pts(2'd3, 32'shAAAA_AAAA, 32'sh5555_5555, 32'sh5555_5555, 32'shAAAA_AAAA,
                       COORD_MIN, COORD_MAX));
      send_item(pts(2'd3, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                       COORD_MAX));
      send_item(pts(2'd3, -7, 3, 4, -9, 11, 13));
      send_item(pts(2'd3, 0, 0, 1, 1, 2, 2));                   // zero cross product

      // reset limits, random traffic, with one long receiver hold-off
      random_run(60);
      hold_off_req = 1'b1;
      random_run(140);
      drain();

      // all limits at zero: only exact collinearity counts as collinear, only a zero radius as too small
      set_limits(32'd0, 32'd0, 16'd0);
      send_item(pts(2'd3, 0, 0, 1, 1, 2, 2));
      send_item(pts(2'd2, 4, 4, 4, 4, 0, 0));
      random_run(160);
      drain();

      // all limits at their top
      set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      random_run(160);
      drain();

      // random middle settings
      set_limits($urandom_range(0, 32'h000F_FFFF), $urandom, 16'($urandom));
      random_run(160);
      drain();

      // back to defaults, back to back on both sides
      set_limits(COLLINEAR_LIMIT_RESET, COINCIDE_LIMIT_RESET, MIN_RADIUS_RESET);
      idle_on = 1'b0;
      random_run(140);
      drain();

      $display("%0d items: %0d circumcircles, %0d diameter circles, %0d too few,",
               circles.items, circles.status_seen[ST_CIRCLE],
               circles.status_seen[ST_DIAMETER], circles.status_seen[ST_FEW]);
      $display("  %0d collinear, %0d too small, over five limit settings",
               circles.status_seen[ST_COLLINEAR], circles.status_seen[ST_SMALL]);
      if (circles.errors == 0 && circles.owed.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
